// ----- rtl/kcs_pkg.sv -----
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared constants, function codes and the queued item type for the keyword
// substitution cipher.
// ----------------------------------------------------------------------------
package kcs_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int IDX_W         = 5;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = 2;
	localparam int QCNT_W        = 3;

	localparam logic [1:0] FN_START  = 2'd0;
	localparam logic [1:0] FN_KEY    = 2'd1;
	localparam logic [1:0] FN_FINISH = 2'd2;
	localparam logic [1:0] FN_TEXT   = 2'd3;

	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UZ = 8'h5A;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LZ = 8'h7A;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(ALPHABET_SIZE);

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       chr;
		logic             letter;
		logic             lower;
		logic [IDX_W-1:0] idx;
	} kcs_item_t;

endpackage

// ----- rtl/kcs_front.sv -----
// ----------------------------------------------------------------------------
// kcs_front
// Accepts input items, classifies the character as upper case letter, lower
// case letter or other, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module kcs_front (
	input  logic              item_valid,
	input  logic [1:0]        func,
	input  logic [7:0]        char_in,
	output logic              item_stall,
	input  logic              q_full,
	output logic              push,
	output kcs_pkg::kcs_item_t push_item
);

	logic is_upper;
	logic is_lower;

	always_comb begin
		is_upper = (char_in >= kcs_pkg::CHAR_UA) && (char_in <= kcs_pkg::CHAR_UZ);
		is_lower = (char_in >= kcs_pkg::CHAR_LA) && (char_in <= kcs_pkg::CHAR_LZ);
		push_item.func   = func;
		push_item.chr    = char_in;
		push_item.letter = is_upper || is_lower;
		push_item.lower  = is_lower;
		if (is_lower) begin
			push_item.idx = kcs_pkg::IDX_W'(char_in - kcs_pkg::CHAR_LA);
		end else begin
			push_item.idx = kcs_pkg::IDX_W'(char_in - kcs_pkg::CHAR_UA);
		end
	end

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

endmodule

// ----- rtl/kcs_queue.sv -----
// ----------------------------------------------------------------------------
// kcs_queue
// Small first-in first-out queue of classified items between the front and
// the back of the cipher.
// ----------------------------------------------------------------------------
module kcs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kcs_pkg::kcs_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output kcs_pkg::kcs_item_t head_item
);

	kcs_pkg::kcs_item_t               mem_q [kcs_pkg::QUEUE_DEPTH];
	logic [kcs_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [kcs_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [kcs_pkg::QCNT_W-1:0]       count_q;

	assign full       = (count_q == kcs_pkg::QCNT_W'(kcs_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/kcs_back.sv -----
// ----------------------------------------------------------------------------
// kcs_back
// Executes queued items: builds the cipher and inverse tables from the
// keyword, walks the alphabet on finish, and substitutes text characters
// into the output register.
// ----------------------------------------------------------------------------
module kcs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic               cfg_wdata,
	input  logic               head_valid,
	input  kcs_pkg::kcs_item_t head_item,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         out_char,
	output logic               not_ready
);

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_FILL = 1'b1;

	logic                              state_q;
	logic [kcs_pkg::IDX_W-1:0]         walk_q;
	logic [kcs_pkg::ALPHABET_SIZE-1:0] used_q;
	logic [kcs_pkg::IDX_W-1:0]         fill_q;
	logic                              key_open_q;
	logic                              mode_q;
	logic [kcs_pkg::IDX_W-1:0]         cipher_q  [kcs_pkg::ALPHABET_SIZE];
	logic [kcs_pkg::IDX_W-1:0]         inverse_q [kcs_pkg::ALPHABET_SIZE];
	logic                              out_valid_q;
	logic [7:0]                        out_char_q;
	logic                              not_ready_q;

	logic                      out_free;
	logic                      is_text;
	logic                      append_en;
	logic [kcs_pkg::IDX_W-1:0] append_idx;
	logic [kcs_pkg::IDX_W-1:0] lookup;
	logic [kcs_pkg::IDX_W-1:0] mapped;
	logic [7:0]                base;
	logic [7:0]                text_out;

	assign out_free = !out_valid_q || !result_stall;
	assign is_text  = (head_item.func == kcs_pkg::FN_TEXT);
	assign pop      = (state_q == ST_RUN) && head_valid && (!is_text || out_free);

	always_comb begin
		append_en  = 1'b0;
		append_idx = head_item.idx;
		if (state_q == ST_FILL) begin
			append_idx = walk_q;
			append_en  = !used_q[walk_q] && (fill_q < kcs_pkg::IDX_FULL);
		end else if (pop && (head_item.func == kcs_pkg::FN_KEY)) begin
			append_en = key_open_q && head_item.letter && !used_q[head_item.idx]
				&& (fill_q < kcs_pkg::IDX_FULL);
		end
	end

	always_comb begin
		lookup = mode_q ? inverse_q[head_item.idx] : cipher_q[head_item.idx];
		mapped = (lookup < kcs_pkg::IDX_FULL) ? lookup : head_item.idx;
		base   = head_item.lower ? kcs_pkg::CHAR_LA : kcs_pkg::CHAR_UA;
		if (key_open_q || !head_item.letter) begin
			text_out = head_item.chr;
		end else begin
			text_out = base + {3'b000, mapped};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			walk_q      <= '0;
			used_q      <= '0;
			fill_q      <= '0;
			key_open_q  <= 1'b0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < kcs_pkg::ALPHABET_SIZE; i++) begin
				cipher_q[i]  <= kcs_pkg::IDX_W'(i);
				inverse_q[i] <= kcs_pkg::IDX_W'(i);
			end
		end else begin
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end
			if (append_en) begin
				cipher_q[fill_q]      <= append_idx;
				inverse_q[append_idx] <= fill_q;
				fill_q                <= fill_q + 1'b1;
				used_q[append_idx]    <= 1'b1;
			end
			if (pop && is_text) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (pop && (head_item.func == kcs_pkg::FN_START)) begin
						used_q     <= '0;
						fill_q     <= '0;
						key_open_q <= 1'b1;
					end else if (pop && (head_item.func == kcs_pkg::FN_FINISH) && key_open_q) begin
						state_q <= ST_FILL;
						walk_q  <= '0;
					end
				end
				ST_FILL: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == kcs_pkg::IDX_LAST) begin
						state_q    <= ST_RUN;
						key_open_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_text) begin
			out_char_q  <= text_out;
			not_ready_q <= key_open_q;
		end
	end

	assign result_valid = out_valid_q;
	assign out_char     = out_char_q;
	assign not_ready    = not_ready_q;

endmodule

// ----- rtl/keyword_substitution_cipher.sv -----
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword monoalphabetic substitution cipher with a classifying front end,
// an item queue and a table-driven back end.
// ----------------------------------------------------------------------------
// Start, keyword and text items are each handled as the back end pops them,
// so text characters are substituted at one item per cycle while the result
// is not stalled and no alphabet walk runs. A text result passes through the
// queue and then the output register. A finish item with a keyword open
// starts the fill state, which walks the alphabet and appends each letter the
// keyword left unused. The four-entry queue keeps accepting items during that
// walk. The mode register may be written only when no item is pending.
module keyword_substitution_cipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] func,
	input  logic [7:0] char_in,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_char,
	output logic       not_ready
);

	logic               q_full;
	logic               push;
	logic               pop;
	logic               head_valid;
	kcs_pkg::kcs_item_t push_item;
	kcs_pkg::kcs_item_t head_item;

	kcs_front u_front (
		.item_valid (item_valid),
		.func       (func),
		.char_in    (char_in),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	kcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	kcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_char     (out_char),
		.not_ready    (not_ready)
	);

endmodule

// ----- rtl/kcs_checker.sv -----
// ----------------------------------------------------------------------------
// kcs_checker
// Port-level checks for the keyword substitution cipher, bound to the top
// level.
// ----------------------------------------------------------------------------
module kcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] func,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] out_char,
	input logic       not_ready
);

	logic [3:0] pending_q;
	logic       text_in;
	logic       result_out;

	assign text_in    = item_valid && !item_stall && (func == kcs_pkg::FN_TEXT);
	assign result_out = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (text_in && !result_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (result_out && !text_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("A stalled result item was withdrawn.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(out_char) && $stable(not_ready))
		else $error("A stalled result item changed.");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 4'd0)
		else $error("A result item appeared without a pending text item.");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(kcs_pkg::QUEUE_DEPTH + 1))
		else $error("More text items are pending than the block can hold.");

endmodule

bind keyword_substitution_cipher kcs_checker u_kcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.func         (func),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.out_char     (out_char),
	.not_ready    (not_ready)
);

// ----- tb/tb_keyword_substitution_cipher.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher
// Self-checking testbench for the keyword substitution cipher. A directed
// opening covers closed-state keyword items, restarts, repeats, non-letters
// and the letter boundaries, then random keyword loads and text runs follow
// under both modes. A local model of the cipher tables predicts every text
// result, and each result item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher;
	import kcs_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = (QUEUE_DEPTH + 2) * (ALPHABET_SIZE + 1) + 16;
	localparam int PHASE_ITEMS  = 245;
	localparam int IDLE_PCT     = 22;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] chr;
	} cipher_cmd_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       not_ready;
	} text_result_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cfg_wen      = 1'b0;
	logic       cfg_wdata    = 1'b0;
	logic       item_valid   = 1'b0;
	logic [1:0] func         = FN_START;
	logic [7:0] char_in      = 8'h00;
	logic       result_stall = 1'b0;
	logic       item_stall;
	logic       result_valid;
	logic [7:0] out_char;
	logic       not_ready;

	cipher_cmd_t  cmd_q[$];
	text_result_t cipher_out_q[$];

	logic [ALPHABET_SIZE-1:0] used_map;
	logic [IDX_W-1:0]         cipher_map [ALPHABET_SIZE];
	logic [IDX_W-1:0]         inverse_map [ALPHABET_SIZE];
	logic [IDX_W-1:0]         fill_count;
	logic                     key_open;
	logic                     mode_reg;

	logic no_idle = 1'b0;
	int   error_count;
	int   items_sent;
	int   texts_checked;
	int   keys_closed;
	int   cycle_count;

	keyword_substitution_cipher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.char_in      (char_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_char     (out_char),
		.not_ready    (not_ready)
	);

	always #CLK_HALF clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void alphabet_append(input logic [IDX_W-1:0] idx);
		if (fill_count >= IDX_FULL || used_map[idx])
			return;
		cipher_map[fill_count] = idx;
		inverse_map[idx] = fill_count;
		fill_count = fill_count + 1'b1;
		used_map[idx] = 1'b1;
	endfunction

	function automatic void predict_cipher_item(input logic [1:0] fn, input logic [7:0] c);
		text_result_t     r;
		logic [7:0]       up;
		logic [7:0]       base;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] m;
		case (fn)
			FN_START: begin
				used_map = '0;
				fill_count = '0;
				key_open = 1'b1;
			end
			FN_KEY: begin
				if (key_open) begin
					up = c;
					if (c >= CHAR_LA && c <= CHAR_LZ)
						up = c - (CHAR_LA - CHAR_UA);
					if (up >= CHAR_UA && up <= CHAR_UZ)
						alphabet_append(IDX_W'(up - CHAR_UA));
				end
			end
			FN_FINISH: begin
				if (key_open) begin
					for (int i = 0; i < ALPHABET_SIZE; i++)
						alphabet_append(IDX_W'(i));
					key_open = 1'b0;
					keys_closed++;
				end
			end
			default: begin
				r.out_char = c;
				r.not_ready = key_open;
				if (!key_open) begin
					base = 8'h00;
					if (c >= CHAR_UA && c <= CHAR_UZ)
						base = CHAR_UA;
					else if (c >= CHAR_LA && c <= CHAR_LZ)
						base = CHAR_LA;
					if (base != 8'h00) begin
						idx = IDX_W'(c - base);
						m = mode_reg ? inverse_map[idx] : cipher_map[idx];
						if (m > IDX_LAST)
							m = idx;
						r.out_char = base + 8'(m);
					end
				end
				cipher_out_q.push_back(r);
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_cipher_item(func, char_in);
				items_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (cmd_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					item_valid <= 1'b1;
					func <= cmd_q[0].func;
					char_in <= cmd_q[0].chr;
					void'(cmd_q.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		text_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (cipher_out_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result out_char=%02h not_ready=%0b",
						out_char, not_ready));
				end else begin
					want = cipher_out_q.pop_front();
					texts_checked++;
					if (out_char !== want.out_char)
						report_mismatch($sformatf("out_char %02h, expected %02h",
							out_char, want.out_char));
					if (not_ready !== want.not_ready)
						report_mismatch($sformatf("not_ready %0b, expected %0b",
							not_ready, want.not_ready));
				end
			end
			result_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycle_count,
				cipher_out_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void push_cmd(input logic [1:0] fn, input logic [7:0] c);
		cipher_cmd_t cmd;
		cmd.func = fn;
		cmd.chr = c;
		cmd_q.push_back(cmd);
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? CHAR_LA : CHAR_UA;
		return base + 8'($urandom_range(ALPHABET_SIZE - 1));
	endfunction

	function automatic logic [7:0] rand_text_char();
		if ($urandom_range(99) < 75)
			return rand_letter();
		return 8'($urandom_range(255));
	endfunction

	// Returns the number of items queued that exercise the cipher; pure noise
	// is not counted since most of it is ignored by the block.
	function automatic int queue_session();
		int kind;
		int n;
		int k;
		int tmp;
		int perm [ALPHABET_SIZE];
		kind = $urandom_range(99);
		n = 0;
		if (kind < 15) begin
			repeat ($urandom_range(1, 6))
				push_cmd(2'($urandom_range(3)), 8'($urandom_range(255)));
			return 0;
		end
		push_cmd(FN_START, 8'($urandom_range(255)));
		n++;
		if (kind < 25) begin
			// A keyword that uses every letter, followed by extra letters.
			for (int i = 0; i < ALPHABET_SIZE; i++)
				perm[i] = i;
			for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
				k = $urandom_range(i);
				tmp = perm[i];
				perm[i] = perm[k];
				perm[k] = tmp;
			end
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				push_cmd(FN_KEY, ($urandom_range(1) ? CHAR_LA : CHAR_UA) + 8'(perm[i]));
				n++;
			end
			repeat ($urandom_range(1, 4)) begin
				push_cmd(FN_KEY, rand_letter());
				n++;
			end
		end else begin
			repeat ($urandom_range(0, 9)) begin
				push_cmd(FN_KEY, ($urandom_range(99) < 85) ? rand_letter()
					: 8'($urandom_range(255)));
				n++;
			end
		end
		if (kind >= 25 && kind < 35) begin
			repeat ($urandom_range(1, 3)) begin
				push_cmd(FN_TEXT, rand_text_char());
				n++;
			end
			if ($urandom_range(1) == 0)
				return n;
		end
		push_cmd(FN_FINISH, 8'($urandom_range(255)));
		n++;
		repeat ($urandom_range(2, 20)) begin
			push_cmd(FN_TEXT, rand_text_char());
			n++;
		end
		return n;
	endfunction

	task automatic wait_idle();
		while (cmd_q.size() != 0 || item_valid || cipher_out_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		mode_reg = value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int count;
		used_map = '0;
		fill_count = '0;
		key_open = 1'b0;
		mode_reg = 1'b0;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			cipher_map[i] = IDX_W'(i);
			inverse_map[i] = IDX_W'(i);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_cmd(FN_TEXT, CHAR_UA);
		push_cmd(FN_KEY, 8'h51);
		push_cmd(FN_FINISH, 8'h00);
		push_cmd(FN_START, 8'h00);
		push_cmd(FN_KEY, 8'h78);
		push_cmd(FN_KEY, 8'h59);
		push_cmd(FN_TEXT, 8'h6D);
		push_cmd(FN_START, 8'hFF);
		push_cmd(FN_KEY, CHAR_LZ);
		push_cmd(FN_KEY, 8'h65);
		push_cmd(FN_KEY, 8'h45);
		push_cmd(FN_KEY, 8'h35);
		push_cmd(FN_KEY, 8'hFF);
		push_cmd(FN_KEY, CHAR_LA);
		push_cmd(FN_FINISH, 8'hFF);
		push_cmd(FN_TEXT, CHAR_UA);
		push_cmd(FN_TEXT, CHAR_UZ);
		push_cmd(FN_TEXT, CHAR_LA);
		push_cmd(FN_TEXT, CHAR_LZ);
		push_cmd(FN_TEXT, CHAR_UA - 8'd1);
		push_cmd(FN_TEXT, CHAR_UZ + 8'd1);
		push_cmd(FN_TEXT, CHAR_LA - 8'd1);
		push_cmd(FN_TEXT, CHAR_LZ + 8'd1);
		push_cmd(FN_TEXT, 8'h00);
		push_cmd(FN_TEXT, 8'hFF);
		wait_idle();

		for (int phase = 0; phase < 5; phase++) begin
			write_mode((phase % 2) == 0);
			no_idle = (phase == 2);
			count = 0;
			while (count < PHASE_ITEMS)
				count += queue_session();
			wait_idle();
		end

		$display("Sent %0d items in both modes, %0d keywords closed.", items_sent, keys_closed);
		$display("Checked %0d text results, %0d mismatches.", texts_checked, error_count);
		if (error_count == 0 && cipher_out_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
